[rtl/rgb_to_hsl_converter_top_defines.svh]
// Assertion macros shared by the converter checker.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define HSL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsl check failed");

// next-cycle implication, off during reset
`define HSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsl check failed");

`endif

[rtl/hsl_pkg.sv]
// Shared types, constants and the divider step of the RGB-to-HSL converter.
// No dependencies.
package hsl_pkg;

    localparam int DIV_STEPS = 8;               // quotient bits, one per stage
    localparam int NSTAGE    = DIV_STEPS + 2;   // two prep stages plus divider

    localparam logic [15:0] HUE_K40   = 16'd40;
    localparam logic [15:0] HUE_K80   = 16'd80;
    localparam logic [15:0] HUE_K160  = 16'd160;
    localparam logic [15:0] HUE_K240  = 16'd240;
    localparam logic [8:0]  SUM_HALF  = 9'd255;
    localparam logic [8:0]  SUM_FULL  = 9'd510;
    // floor(sum*8/17) == (sum*61681) >> 17 for sum in 0..510
    localparam logic [15:0] LIGHT_RECIP = 16'd61681;
    localparam int          LIGHT_SHIFT = 17;
    localparam int          LIGHT_PW    = 25;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

    // one division in flight: partial remainder, dividend low bits
    // shifting out while quotient bits shift in, divisor
    typedef struct packed {
        logic [7:0] part;
        logic [7:0] lowq;
        logic [7:0] den;
    } hsl_lane_t;

    typedef struct packed {
        hsl_lane_t  sat;
        hsl_lane_t  hue;
        logic       grey;
        logic [7:0] light;
    } hsl_stage_t;

    // one restoring step; requires part < den on entry
    function automatic hsl_lane_t div_step(input hsl_lane_t lane);
        logic [8:0] trial;
        logic [8:0] diff;
        hsl_lane_t  res;
        trial    = {lane.part, lane.lowq[7]};
        diff     = trial - {1'b0, lane.den};
        res.den  = lane.den;
        if (trial >= {1'b0, lane.den})
        begin
            res.part = diff[7:0];
            res.lowq = {lane.lowq[6:0], 1'b1};
        end
        else
        begin
            res.part = trial[7:0];
            res.lowq = {lane.lowq[6:0], 1'b0};
        end
        return res;
    endfunction

endpackage

[rtl/hsl_if.sv]
// Handshake channels of the converter: pixel in, HSL result out.
// No dependencies.
interface hsl_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface hsl_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

[rtl/hsl_prep.sv]
// First two pipeline stages: channel max/min, then dividends, divisors,
// hue offset and lightness. Depends on hsl_pkg.
module hsl_prep (
    input  logic                clk,
    input  logic                en_a,
    input  logic                en_b,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    output hsl_pkg::hsl_stage_t stage_out
);

    localparam int LIGHT_W = hsl_pkg::LIGHT_PW;

    logic [7:0]        red_reg, green_reg, blue_reg;
    logic [7:0]        mx_reg, mn_reg;
    hsl_pkg::max_sel_t sel_reg;

    logic [7:0]        mx_next, mn_next;
    hsl_pkg::max_sel_t sel_next;

    hsl_pkg::hsl_stage_t stage_reg, stage_next;

    logic [7:0]  d;
    logic [8:0]  sum;
    logic [8:0]  den_hi;
    logic [7:0]  denom;
    logic [15:0] sat_num;
    logic [15:0] hue_num;
    logic [15:0] d16, r16, g16, b16;
    logic [LIGHT_W-1:0] light_prod;

    // stage A: extremes; ties favor red, then green
    always_comb
    begin
        mx_next  = red;
        mn_next  = red;
        if (green > mx_next) mx_next = green;
        if (blue  > mx_next) mx_next = blue;
        if (green < mn_next) mn_next = green;
        if (blue  < mn_next) mn_next = blue;
        if (red == mx_next)
            sel_next = hsl_pkg::SEL_RED;
        else if (green == mx_next)
            sel_next = hsl_pkg::SEL_GREEN;
        else
            sel_next = hsl_pkg::SEL_BLUE;
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            mx_reg    <= mx_next;
            mn_reg    <= mn_next;
            sel_reg   <= sel_next;
        end
    end

    // stage B
    assign d      = mx_reg - mn_reg;
    assign sum    = {1'b0, mx_reg} + {1'b0, mn_reg};
    assign den_hi = hsl_pkg::SUM_FULL - sum;
    assign denom  = (sum < hsl_pkg::SUM_HALF) ? sum[7:0] : den_hi[7:0];
    assign d16    = {8'd0, d};
    assign r16    = {8'd0, red_reg};
    assign g16    = {8'd0, green_reg};
    assign b16    = {8'd0, blue_reg};
    assign sat_num = d16 * hsl_pkg::HUE_K240;

    // hue scaled by 240*d, already wrapped into [0, 240*d)
    always_comb
    begin
        case (sel_reg)
            hsl_pkg::SEL_RED:
            begin
                if (green_reg >= blue_reg)
                    hue_num = (g16 - b16) * hsl_pkg::HUE_K40;
                else
                    hue_num = sat_num - (b16 - g16) * hsl_pkg::HUE_K40;
            end
            hsl_pkg::SEL_GREEN:
                hue_num = d16 * hsl_pkg::HUE_K80 + b16 * hsl_pkg::HUE_K40
                          - r16 * hsl_pkg::HUE_K40;
            default:
                hue_num = d16 * hsl_pkg::HUE_K160 + r16 * hsl_pkg::HUE_K40
                          - g16 * hsl_pkg::HUE_K40;
        endcase
    end

    assign light_prod = LIGHT_W'(sum) * LIGHT_W'(hsl_pkg::LIGHT_RECIP);

    always_comb
    begin
        stage_next.sat.part = sat_num[15:8];
        stage_next.sat.lowq = sat_num[7:0];
        stage_next.sat.den  = denom;
        stage_next.hue.part = hue_num[15:8];
        stage_next.hue.lowq = hue_num[7:0];
        stage_next.hue.den  = d;
        stage_next.grey     = (d == 8'd0);
        stage_next.light    = light_prod[hsl_pkg::LIGHT_SHIFT+7:hsl_pkg::LIGHT_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

[rtl/hsl_div_stage.sv]
// One stage of the pipelined divider: a restoring step on both the
// saturation and the hue quotient. Depends on hsl_pkg.
module hsl_div_stage (
    input  logic                clk,
    input  logic                en,
    input  hsl_pkg::hsl_stage_t stage_in,
    output hsl_pkg::hsl_stage_t stage_out
);

    hsl_pkg::hsl_stage_t stage_reg, stage_next;

    always_comb
    begin
        stage_next       = stage_in;
        stage_next.sat   = hsl_pkg::div_step(stage_in.sat);
        stage_next.hue   = hsl_pkg::div_step(stage_in.hue);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

[rtl/rgb_to_hsl_converter_top.sv]
// Top level of the RGB-to-HSL converter: valid/stall control around the
// prep stages and the divider stages. Depends on hsl_pkg, hsl_if, hsl_prep, hsl_div_stage.
//
//  channel | dir | payload                          | transaction
//  --------+-----+----------------------------------+----------------------
//  pix     | in  | red, green, blue (8b each)       | valid && ready at clk
//  hsl     | out | hue, saturation, lightness (8b)  | valid && ready at clk
//
// One pixel per cycle sustained while the output is not stalled; 10 register stages
// (2 prep stages plus 8 divider stages, one quotient bit each), the result being
// valid once the pixel has passed through all of them.
// rst_n clears only the stage valid bits.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under an output stall and no item is dropped or doubled.
module rgb_to_hsl_converter_top (
    input  logic          clk,
    input  logic          rst_n,
    hsl_pix_if.sink       pix,
    hsl_res_if.source     hsl
);

    localparam int NS = hsl_pkg::NSTAGE;
    localparam int DS = hsl_pkg::DIV_STEPS;

    logic [NS-1:0] valid_reg, valid_next, ld;

    hsl_pkg::hsl_stage_t stage_data [DS+1];

    assign ld[NS-1] = !valid_reg[NS-1] || hsl.ready;

    genvar gi;
    generate
        for (gi = 0; gi < NS - 1; gi++)
        begin : g_ld
            assign ld[gi] = !valid_reg[gi] || ld[gi+1];
        end
    endgenerate

    assign valid_next[0] = ld[0] ? pix.valid : valid_reg[0];
    generate
        for (gi = 1; gi < NS; gi++)
        begin : g_vld
            assign valid_next[gi] = ld[gi] ? valid_reg[gi-1] : valid_reg[gi];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign pix.ready = ld[0];

    hsl_prep u_prep (
        .clk       (clk),
        .en_a      (ld[0]),
        .en_b      (ld[1]),
        .red       (pix.red),
        .green     (pix.green),
        .blue      (pix.blue),
        .stage_out (stage_data[0])
    );

    generate
        for (gi = 0; gi < DS; gi++)
        begin : g_div
            hsl_div_stage u_div (
                .clk       (clk),
                .en        (ld[gi+2]),
                .stage_in  (stage_data[gi]),
                .stage_out (stage_data[gi+1])
            );
        end
    endgenerate

    // grey pixels carry junk quotients (divisor may be zero)
    assign hsl.valid      = valid_reg[NS-1];
    assign hsl.hue        = stage_data[DS].grey ? 8'd0 : stage_data[DS].hue.lowq;
    assign hsl.saturation = stage_data[DS].grey ? 8'd0 : stage_data[DS].sat.lowq;
    assign hsl.lightness  = stage_data[DS].light;

endmodule

[rtl/hsl_checker.sv]
// Port-level checks on the converter, bound to the top level.
// Depends on rgb_to_hsl_converter_top_defines.svh.
`include "rgb_to_hsl_converter_top_defines.svh"

module hsl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pix_ready,
    input logic       hsl_valid,
    input logic       hsl_ready,
    input logic [7:0] hsl_hue,
    input logic [7:0] hsl_saturation,
    input logic [7:0] hsl_lightness
);

    logic        in_range;
    logic [23:0] hsl_data;

    assign in_range = (hsl_hue <= 8'd239) && (hsl_saturation <= 8'd240)
                      && (hsl_lightness <= 8'd240);
    assign hsl_data = {hsl_hue, hsl_saturation, hsl_lightness};

    // results stay on the 0..240 scale, hue below a full turn
    `HSL_ASSERT_IMPLY(a_range, hsl_valid, in_range)

    // a stalled transaction holds
    `HSL_ASSERT_NEXT(a_hold, hsl_valid && !hsl_ready, hsl_valid && $stable(hsl_data))

    // an empty output stage never blocks the input
    `HSL_ASSERT_IMPLY(a_no_block, !hsl_valid, pix_ready)

    // pipeline comes out of reset empty
    `HSL_ASSERT_IMPLY(a_reset_empty, $rose(rst_n), !hsl_valid)

endmodule

bind rgb_to_hsl_converter_top hsl_checker u_hsl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_ready      (pix.ready),
    .hsl_valid      (hsl.valid),
    .hsl_ready      (hsl.ready),
    .hsl_hue        (hsl.hue),
    .hsl_saturation (hsl.saturation),
    .hsl_lightness  (hsl.lightness)
);
